@@ hdl/clcd_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble sequencer.
// No dependencies; every other file in hdl/ refers to this package by scope.
`timescale 1ns / 1ps
package clcd_pkg;

   localparam int LINE_BYTES = 32;
   localparam int LB_AW      = $clog2(LINE_BYTES);
   localparam int LB_CW      = $clog2(LINE_BYTES + 1);

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_INIT  = 3'd1;
   localparam logic [2:0] OP_DATA  = 3'd2;
   localparam logic [2:0] OP_CMD   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;
   localparam logic [2:0] OP_HOME  = 3'd5;
   localparam logic [2:0] OP_LOAD  = 3'd6;
   localparam logic [2:0] OP_LINE  = 3'd7;

   localparam logic [1:0] CSR_WAIT_POWERUP = 2'd0;
   localparam logic [1:0] CSR_PULSE_TICKS  = 2'd1;
   localparam logic [1:0] CSR_NIBBLE_GAP   = 2'd2;
   localparam logic [1:0] CSR_BYTE_GAP     = 2'd3;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_POWERUP = 2'd1;
   localparam logic [1:0] PH_PULSE   = 2'd2;
   localparam logic [1:0] PH_GAP     = 2'd3;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_LINE2_ADDR = 8'hC0;
   localparam logic [7:0] CMD_LINE1_ADDR = 8'h80;
   localparam logic [7:0] POWERUP_TICKS  = 8'd100;
   localparam logic [7:0] FIRST_GAP      = 8'd25;
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_4BIT       = 4'h2;
   localparam logic [1:0] LINE_SECOND    = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] value;
      logic [1:0] line_num;
   } req_type;

   typedef struct packed {
      logic [3:0] bus_nibble;
      logic       reg_select;
      logic       enable_pin;
      logic       busy_res;
      logic       line_done;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [LB_AW-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h28;
         3'd1:    b = 8'h08;
         3'd2:    b = 8'h01;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h0F;
         default: b = 8'h0F;
      endcase
      return b;
   endfunction

endpackage

@@ hdl/char_lcd_nibble_sequencer.sv @@
// Character LCD nibble sequencer, 4-bit bus, top level.
// Uses clcd_pkg, clcd_core, clcd_line_store and clcd_out_stage.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one item is a tick or a
//   request (init, data byte, command byte, clear, home, load line byte,
//   start line). Every item yields exactly one item on rsp.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): pin levels, busy, line done
//   and reject flags as they stand after the item.
//   csr channel (csr_valid/csr_ready/csr_index/csr_wdata): timing registers,
//   always ready; write only while the block is idle.
// A result is registered in the output stage, or in its skid entry while rsp stalls.
// Throughput: one item per cycle while req_ready is high; the next-state logic
//   of clcd_core is combinational, and the line store read is prefetched for the next item.
// Reset (synchronous, active high): sequencer idle, pins low with register
//   select high, line store empty, timing registers at their defaults.
// When rsp stalls, one more item is taken into the skid entry; req_ready
//   then drops until rsp drains.
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  clcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clcd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   logic                             fire;
   clcd_pkg::rsp_type                result;
   clcd_pkg::store_wr_type           store_wr;
   logic [clcd_pkg::LB_AW-1:0]       store_rd_addr;
   logic [7:0]                       store_rd_data;

   assign fire      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   clcd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .req           (req_data),
      .csr_we        (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .store_wr      (store_wr),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .result        (result)
   );

   clcd_line_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   clcd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fire),
      .in_data   (result),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/clcd_line_store.sv @@
// Line byte store: one write port, one registered read port.
// Depends on clcd_pkg for depth, address width and the write struct.
`timescale 1ns / 1ps
module clcd_line_store (
   input  logic                         clock,
   input  clcd_pkg::store_wr_type       wr,
   input  logic [clcd_pkg::LB_AW-1:0]   rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem_ff [clcd_pkg::LINE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/clcd_out_stage.sv @@
// Result register with a skid entry so an item can be taken while rsp stalls.
// Depends on clcd_pkg for the result struct.
`timescale 1ns / 1ps
module clcd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  clcd_pkg::rsp_type in_data,
   output logic              in_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clcd_pkg::rsp_type rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   clcd_pkg::rsp_type out_ff, out_in;
   clcd_pkg::rsp_type skid_ff, skid_in;

   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_in       = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hdl/clcd_core.sv @@
// Sequencer state, timing registers and per-item next-state logic.
// Depends on clcd_pkg; reads the line store through a registered read port.
`timescale 1ns / 1ps
module clcd_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  clcd_pkg::req_type            req,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [7:0]                   csr_wdata,
   output clcd_pkg::store_wr_type       store_wr,
   output logic [clcd_pkg::LB_AW-1:0]   store_rd_addr,
   input  logic [7:0]                   store_rd_data,
   output clcd_pkg::rsp_type            result
);

   logic       wait_powerup_ff;
   logic [7:0] pulse_ticks_ff, nibble_gap_ff, byte_gap_ff;

   logic [1:0]                 phase_ff, phase_in;
   logic [7:0]                 tick_ff, tick_in;
   logic [3:0]                 step_ff, step_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       lowp_ff, lowp_in;
   logic [3:0]                 nib_ff, nib_in;
   logic                       rs_ff, rs_in;
   logic                       en_ff, en_in;
   logic [clcd_pkg::LB_CW-1:0] lcount_ff, lcount_in;
   logic [clcd_pkg::LB_CW-1:0] lptr_ff, lptr_in;
   logic                       lact_ff, lact_in;

   logic       done, rej, busy, init_early;
   logic       start_nib, start_byte, do_pulse_end, do_gap_end, do_next, do_idle;
   logic [3:0] nib_val;
   logic [7:0] byte_val, gap, tick_dec;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      step_in   = step_ff;
      byte_in   = byte_ff;
      lowp_in   = lowp_ff;
      nib_in    = nib_ff;
      rs_in     = rs_ff;
      en_in     = en_ff;
      lcount_in = lcount_ff;
      lptr_in   = lptr_ff;
      lact_in   = lact_ff;
      done      = 1'b0;
      rej       = 1'b0;
      store_wr  = '0;
      start_nib    = 1'b0;
      start_byte   = 1'b0;
      do_pulse_end = 1'b0;
      do_gap_end   = 1'b0;
      do_next      = 1'b0;
      do_idle      = 1'b0;
      nib_val   = '0;
      byte_val  = '0;
      gap       = '0;
      tick_dec  = (tick_ff == 8'd0) ? 8'd0 : tick_ff - 8'd1;
      busy       = (phase_ff != clcd_pkg::PH_IDLE);
      init_early = (step_ff >= 4'd1) && (step_ff <= 4'd4);

      if (req.op == clcd_pkg::OP_TICK) begin
         if (busy) begin
            tick_in = tick_dec;
            if (tick_dec == 8'd0) begin
               case (phase_ff)
                  clcd_pkg::PH_POWERUP: begin
                     step_in   = 4'd1;
                     start_nib = 1'b1;
                     nib_val   = clcd_pkg::NIB_WAKE;
                  end
                  clcd_pkg::PH_PULSE: do_pulse_end = 1'b1;
                  clcd_pkg::PH_GAP:   do_gap_end   = 1'b1;
                  default:            do_idle      = 1'b1;
               endcase
            end
         end
      end else if (busy) begin
         rej = 1'b1;
      end else begin
         case (req.op)
            clcd_pkg::OP_INIT: begin
               rs_in = 1'b0;
               if (wait_powerup_ff) begin
                  step_in  = 4'd0;
                  phase_in = clcd_pkg::PH_POWERUP;
                  tick_in  = clcd_pkg::POWERUP_TICKS;
               end else begin
                  step_in   = 4'd1;
                  start_nib = 1'b1;
                  nib_val   = clcd_pkg::NIB_WAKE;
               end
            end
            clcd_pkg::OP_DATA: begin
               rs_in      = 1'b1;
               start_byte = 1'b1;
               byte_val   = req.value;
            end
            clcd_pkg::OP_CMD: begin
               rs_in      = 1'b0;
               start_byte = 1'b1;
               byte_val   = req.value;
            end
            clcd_pkg::OP_CLEAR: begin
               rs_in      = 1'b0;
               start_byte = 1'b1;
               byte_val   = clcd_pkg::CMD_CLEAR;
            end
            clcd_pkg::OP_HOME: begin
               rs_in      = 1'b0;
               start_byte = 1'b1;
               byte_val   = clcd_pkg::CMD_HOME;
            end
            clcd_pkg::OP_LOAD: begin
               if (lcount_ff < clcd_pkg::LB_CW'(clcd_pkg::LINE_BYTES)) begin
                  store_wr.en   = 1'b1;
                  store_wr.addr = lcount_ff[clcd_pkg::LB_AW-1:0];
                  store_wr.data = req.value;
                  lcount_in     = lcount_ff + 1'b1;
               end else begin
                  rej = 1'b1;
               end
            end
            default: begin
               lact_in    = 1'b1;
               lptr_in    = '0;
               rs_in      = 1'b0;
               start_byte = 1'b1;
               byte_val   = (req.line_num == clcd_pkg::LINE_SECOND) ?
                            clcd_pkg::CMD_LINE2_ADDR : clcd_pkg::CMD_LINE1_ADDR;
            end
         endcase
      end

      // end of enable pulse
      if (do_pulse_end) begin
         en_in = 1'b0;
         if (init_early) begin
            lowp_in = 1'b0;
            gap     = (step_ff == 4'd1) ? clcd_pkg::FIRST_GAP : byte_gap_ff;
         end else begin
            gap = lowp_ff ? nibble_gap_ff : byte_gap_ff;
         end
         phase_in = clcd_pkg::PH_GAP;
         tick_in  = gap;
         if (gap == 8'd0) begin
            do_gap_end = 1'b1;
         end
      end

      // end of gap: low nibble, else next step of the sequence (nibble, byte or idle)
      if (do_gap_end) begin
         if (lowp_in && !init_early) begin
            lowp_in   = 1'b0;
            start_nib = 1'b1;
            nib_val   = byte_ff[3:0];
         end else begin
            do_next = 1'b1;
         end
      end

      if (do_next) begin
         if (step_ff >= 4'd1 && step_ff <= 4'd8) begin
            step_in = step_ff + 4'd1;
            if (step_in <= 4'd4) begin
               start_nib = 1'b1;
               nib_val   = (step_in == 4'd4) ? clcd_pkg::NIB_4BIT : clcd_pkg::NIB_WAKE;
            end else begin
               start_byte = 1'b1;
               byte_val   = clcd_pkg::init_byte(3'(step_in - 4'd5));
            end
         end else if (step_ff != 4'd0) begin
            step_in = 4'd0;
            do_idle = 1'b1;
         end else if (lact_ff) begin
            if (lptr_ff < lcount_ff) begin
               rs_in      = 1'b1;
               start_byte = 1'b1;
               byte_val   = store_rd_data;
               lptr_in    = lptr_ff + 1'b1;
            end else begin
               lact_in   = 1'b0;
               lcount_in = '0;
               lptr_in   = '0;
               done      = 1'b1;
               do_idle   = 1'b1;
            end
         end else begin
            do_idle = 1'b1;
         end
      end

      if (start_byte) begin
         byte_in   = byte_val;
         lowp_in   = 1'b1;
         start_nib = 1'b1;
         nib_val   = byte_val[7:4];
      end

      if (start_nib) begin
         nib_in   = nib_val;
         en_in    = 1'b1;
         phase_in = clcd_pkg::PH_PULSE;
         tick_in  = (pulse_ticks_ff == 8'd0) ? 8'd1 : pulse_ticks_ff;
      end

      if (do_idle) begin
         phase_in = clcd_pkg::PH_IDLE;
         tick_in  = 8'd0;
         rs_in    = 1'b1;
      end

      if (!fire) begin
         store_wr.en = 1'b0;
      end
   end

   // prefetch the entry the pointer will address for the next item
   assign store_rd_addr = fire ? lptr_in[clcd_pkg::LB_AW-1:0] : lptr_ff[clcd_pkg::LB_AW-1:0];

   always_comb begin
      result.bus_nibble = nib_in;
      result.reg_select = rs_in;
      result.enable_pin = en_in;
      result.busy_res   = (phase_in != clcd_pkg::PH_IDLE);
      result.line_done  = done;
      result.rejected   = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_powerup_ff <= 1'b1;
         pulse_ticks_ff  <= 8'd1;
         nibble_gap_ff   <= 8'd2;
         byte_gap_ff     <= 8'd5;
      end else if (csr_we) begin
         case (csr_index)
            clcd_pkg::CSR_WAIT_POWERUP: wait_powerup_ff <= csr_wdata[0];
            clcd_pkg::CSR_PULSE_TICKS:  pulse_ticks_ff  <= csr_wdata;
            clcd_pkg::CSR_NIBBLE_GAP:   nibble_gap_ff   <= csr_wdata;
            clcd_pkg::CSR_BYTE_GAP:     byte_gap_ff     <= csr_wdata;
            default:                    byte_gap_ff     <= byte_gap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= clcd_pkg::PH_IDLE;
         tick_ff   <= '0;
         step_ff   <= '0;
         byte_ff   <= '0;
         lowp_ff   <= 1'b0;
         nib_ff    <= '0;
         rs_ff     <= 1'b1;
         en_ff     <= 1'b0;
         lcount_ff <= '0;
         lptr_ff   <= '0;
         lact_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         step_ff   <= step_in;
         byte_ff   <= byte_in;
         lowp_ff   <= lowp_in;
         nib_ff    <= nib_in;
         rs_ff     <= rs_in;
         en_ff     <= en_in;
         lcount_ff <= lcount_in;
         lptr_ff   <= lptr_in;
         lact_ff   <= lact_in;
      end
   end

endmodule
